@@ rtl/core/gap_buffer_text_store_assert.svh @@
// Assertion macros shared by the gap buffer text store RTL.
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GBTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gbts_pkg.sv @@
// Types and constants of the gap buffer text store.
package gbts_pkg;

    localparam int OP_W   = 3;
    localparam int CHAR_W = 21;
    localparam int POS_W  = 11;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_DELETE    = 3'd2,
        OP_MOVE      = 3'd3,
        OP_READ      = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MV_RD,
        S_MV_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic do_insert;
        logic do_backspace;
        logic do_delete;
        logic set_ok;
        logic rd_read;
        logic rd_move;
        logic move_write;
        logic load_rsp;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            can_insert;
        logic            can_backspace;
        logic            can_delete;
        logic            move_ok;
        logic            read_ok;
        logic            step_need;
        logic            rsp_free;
    } t_status;

endpackage

@@ rtl/core/gbts_req_if.sv @@
// Request channel of the gap buffer text store.
interface gbts_req_if;
    import gbts_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_value;
    logic [POS_W-1:0]  position;

    modport source (output valid, output operation, output char_value, output position,
                    input ready);
    modport sink (input valid, input operation, input char_value, input position,
                  output ready);
endinterface

@@ rtl/core/gbts_rsp_if.sv @@
// Result channel of the gap buffer text store.
interface gbts_rsp_if;
    import gbts_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [CHAR_W-1:0] read_char;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor;

    modport source (output valid, output ok, output read_char, output text_length,
                    output cursor, input ready);
    modport sink (input valid, input ok, input read_char, input text_length,
                  input cursor, output ready);
endinterface

@@ rtl/core/gbts_dp.sv @@
// Datapath: character store, gap pointers, request and result registers.
module gbts_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gbts_pkg::t_cmd           i_cmd,
    output gbts_pkg::t_status        o_status,
    input  logic [gbts_pkg::OP_W-1:0]   i_operation,
    input  logic [gbts_pkg::CHAR_W-1:0] i_char_value,
    input  logic [gbts_pkg::POS_W-1:0]  i_position,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic                        o_ok,
    output logic [gbts_pkg::CHAR_W-1:0] o_read_char,
    output logic [gbts_pkg::POS_W-1:0]  o_text_length,
    output logic [gbts_pkg::POS_W-1:0]  o_cursor
);
    import gbts_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = (PTR_W > POS_W) ? PTR_W : POS_W;
    localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);
    localparam logic [CW-1:0]    CAP_W = CW'(CAPACITY);

    logic [CHAR_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [POS_W-1:0]  r_pos;
    logic [PTR_W-1:0]  r_gap_first, n_gap_first;
    logic [PTR_W-1:0]  r_gap_past, n_gap_past;
    logic [CHAR_W-1:0] r_rdata;
    logic              r_ok;

    logic              r_rsp_valid;
    logic              r_rsp_ok;
    logic [CHAR_W-1:0] r_rsp_char;
    logic [POS_W-1:0]  r_rsp_len;
    logic [POS_W-1:0]  r_rsp_cur;

    logic [PTR_W-1:0]  w_len;
    logic [PTR_W-1:0]  w_first_m1;
    logic [PTR_W-1:0]  w_past_m1;
    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_first;
    logic [CW-1:0]     w_past;
    logic [CW-1:0]     w_lenx;
    logic [CW-1:0]     w_phys;
    logic              w_fwd;
    logic              w_back;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [CHAR_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;

    always_comb begin
        w_len      = r_gap_first + (CAP_P - r_gap_past);
        w_first_m1 = r_gap_first - PTR_W'(1);
        w_past_m1  = r_gap_past - PTR_W'(1);
        w_pos      = CW'(r_pos);
        w_first    = CW'(r_gap_first);
        w_past     = CW'(r_gap_past);
        w_lenx     = CW'(w_len);
        w_fwd      = (w_first < w_pos) && (w_past < CAP_W);
        w_back     = (w_first > w_pos) && (r_gap_first != '0);
        // logical position lands before the gap or past its end
        w_phys     = (w_pos < w_first) ? w_pos : w_pos + (w_past - w_first);
    end

    always_comb begin
        o_status.op            = r_op;
        o_status.can_insert    = r_gap_first < r_gap_past;
        o_status.can_backspace = r_gap_first != '0;
        o_status.can_delete    = w_past < CAP_W;
        o_status.move_ok       = w_pos <= w_lenx;
        o_status.read_ok       = w_pos < w_lenx;
        o_status.step_need     = w_fwd || w_back;
        o_status.rsp_free      = !r_rsp_valid || i_rsp_ready;
    end

    always_comb begin
        w_wr_en   = i_cmd.do_insert || i_cmd.move_write;
        w_rd_en   = i_cmd.rd_read || i_cmd.rd_move;
        w_wr_data = i_cmd.do_insert ? r_char : r_rdata;
        if (i_cmd.do_insert || w_fwd) begin
            w_wr_addr = r_gap_first[AW-1:0];
        end else begin
            w_wr_addr = w_past_m1[AW-1:0];
        end
        if (i_cmd.rd_read) begin
            w_rd_addr = w_phys[AW-1:0];
        end else if (w_fwd) begin
            w_rd_addr = r_gap_past[AW-1:0];
        end else begin
            w_rd_addr = w_first_m1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_gap_first = r_gap_first;
        n_gap_past  = r_gap_past;
        if (i_cmd.do_insert) begin
            n_gap_first = r_gap_first + PTR_W'(1);
        end
        if (i_cmd.do_backspace) begin
            n_gap_first = w_first_m1;
        end
        if (i_cmd.do_delete) begin
            n_gap_past = r_gap_past + PTR_W'(1);
        end
        if (i_cmd.move_write) begin
            if (w_fwd) begin
                n_gap_first = r_gap_first + PTR_W'(1);
                n_gap_past  = r_gap_past + PTR_W'(1);
            end else begin
                n_gap_first = w_first_m1;
                n_gap_past  = w_past_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_first <= '0;
            r_gap_past  <= CAP_P;
            r_rsp_valid <= 1'b0;
        end else begin
            r_gap_first <= n_gap_first;
            r_gap_past  <= n_gap_past;
            if (i_cmd.load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op   <= i_operation;
            r_char <= i_char_value;
            r_pos  <= i_position;
            r_ok   <= 1'b0;
        end else if (i_cmd.set_ok) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.load_rsp) begin
            r_rsp_ok   <= r_ok;
            r_rsp_char <= (r_ok && (r_op == OP_READ)) ? r_rdata : '0;
            r_rsp_len  <= w_lenx[POS_W-1:0];
            r_rsp_cur  <= w_first[POS_W-1:0];
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_ok          = r_rsp_ok;
    assign o_read_char   = r_rsp_char;
    assign o_text_length = r_rsp_len;
    assign o_cursor      = r_rsp_cur;

endmodule

@@ rtl/core/gbts_ctrl.sv @@
// Controller: sequences each request through the datapath.
module gbts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  gbts_pkg::t_status i_status,
    output gbts_pkg::t_cmd    o_cmd
);
    import gbts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_status.op)
                    OP_INSERT: begin
                        if (i_status.can_insert) begin
                            o_cmd.do_insert = 1'b1;
                            o_cmd.set_ok    = 1'b1;
                        end
                    end
                    OP_BACKSPACE: begin
                        if (i_status.can_backspace) begin
                            o_cmd.do_backspace = 1'b1;
                            o_cmd.set_ok       = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (i_status.can_delete) begin
                            o_cmd.do_delete = 1'b1;
                            o_cmd.set_ok    = 1'b1;
                        end
                    end
                    OP_MOVE: begin
                        if (i_status.move_ok) begin
                            o_cmd.set_ok = 1'b1;
                            n_state      = S_MV_RD;
                        end
                    end
                    OP_READ: begin
                        // store data lands in the read register by the done cycle
                        if (i_status.read_ok) begin
                            o_cmd.rd_read = 1'b1;
                            o_cmd.set_ok  = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MV_RD: begin
                if (i_status.step_need) begin
                    o_cmd.rd_move = 1'b1;
                    n_state       = S_MV_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MV_WR: begin
                // copy one character across the gap and step both pointers toward the target
                o_cmd.move_write = 1'b1;
                n_state          = S_MV_RD;
            end
            S_DONE: begin
                // hold until the result register can take the result
                if (i_status.rsp_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gap_buffer_text_store.sv @@
// Insert, backspace, delete, read and a refused move pass from the request register
// through the execute state to the done state; an accepted cursor move also runs a store
// read then a store write for each character shifted. The done state holds until the
// result register is free. One request at a time: a new request is accepted the cycle
// after the result is loaded into the output register. Reset empties the text (cursor 0,
// length 0) and the result register; the character store is not cleared.
module gap_buffer_text_store #(
    parameter int CAPACITY = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbts_req_if.sink   i_req,
    gbts_rsp_if.source o_rsp
);
    import gbts_pkg::*;
    `include "gap_buffer_text_store_assert.svh"

    t_cmd    w_cmd;
    t_status w_status;

    gbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gbts_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_operation   (i_req.operation),
        .i_char_value  (i_req.char_value),
        .i_position    (i_req.position),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_ok          (o_rsp.ok),
        .o_read_char   (o_rsp.read_char),
        .o_text_length (o_rsp.text_length),
        .o_cursor      (o_rsp.cursor)
    );

    `GBTS_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request accepted while another is in flight")
    `GBTS_ASSERT_IMPL(a_insert_room, i_clk, i_rst_n, w_cmd.do_insert, w_status.can_insert, "insert issued into a full store")
    `GBTS_ASSERT_IMPL(a_move_step, i_clk, i_rst_n, w_cmd.move_write, w_status.step_need, "move step issued with cursor already in place")
    `GBTS_ASSERT_IMPL(a_rsp_slot, i_clk, i_rst_n, w_cmd.load_rsp, w_status.rsp_free, "result overwrites an untaken result")

endmodule
